[hw/rtl/msbr_pkg.sv]
package msbr_pkg;

    // Store geometry
    localparam int BUF_BYTES     = 4096;
    localparam int IDX_W         = $clog2(BUF_BYTES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int WORD_BYTES    = 4;
    localparam int LANE_W        = $clog2(WORD_BYTES);
    localparam int BANK_DEPTH    = BUF_BYTES / (2 * WORD_BYTES);
    localparam int BANK_AW       = IDX_W - LANE_W - 1;

    // Field widths
    localparam int MODE_W        = 3;
    localparam int BYTE_W        = 8;
    localparam int AMT_W         = 16;
    localparam int VAL_W         = 24;
    localparam int BIT_W         = 3;
    localparam int MAX_READ_BITS = 24;
    localparam int NB_W          = $clog2(MAX_READ_BITS + 1);
    localparam int WIN_W         = WORD_BYTES * BYTE_W;

    // Bit position widths
    localparam int BH_W          = CNT_W + BIT_W;
    localparam int MV_W          = (AMT_W > BH_W) ? AMT_W : BH_W;
    localparam int NV_W          = $clog2(WORD_BYTES + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND     = 3'd0,
        MODE_READ_BITS  = 3'd1,
        MODE_SKIP_BITS  = 3'd2,
        MODE_BACK_BITS  = 3'd3,
        MODE_SKIP_BYTES = 3'd4,
        MODE_READ_BYTE  = 3'd5
    } t_mode;

    typedef logic [WORD_BYTES-1:0][BYTE_W-1:0] t_win;

    // Memory access issued with an accepted transaction
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    // What the read stage needs to finish a transaction
    typedef struct packed {
        logic              extract;
        logic [BIT_W-1:0]  shift;
        logic [NB_W-1:0]   nbits;
        logic [NV_W-1:0]   nvalid;
        logic [AMT_W-1:0]  moved;
        logic [CNT_W-1:0]  avail;
        logic [CNT_W-1:0]  free;
        logic [BIT_W-1:0]  bit_off;
        logic              short_read;
    } t_rd_info;

endpackage

[hw/rtl/msbr_ctl.sv]
module msbr_ctl
    import msbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [AMT_W-1:0]  i_amount,
    output t_mem_req          o_req,
    output t_rd_info          o_info
);

    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [CNT_W-1:0] r_held, n_held;
    logic [CNT_W-1:0] r_behind, n_behind;

    logic [BH_W-1:0]  bits_held;
    logic [MV_W-1:0]  amt_x;
    logic [MV_W-1:0]  bh_x;
    logic [MV_W-1:0]  limit_x;
    logic [CNT_W-1:0] room_app;
    logic [MV_W-1:0]  moved;
    logic             do_adv;
    logic [BH_W-1:0]  total;
    logic [CNT_W-1:0] bytes_a;
    logic [MV_W-1:0]  back_r;
    logic [MV_W:0]    back_p7;
    logic [CNT_W-1:0] bytes_b;
    logic [CNT_W-1:0] skip_b;
    logic [NB_W-1:0]  nb;

    // Pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_bit    <= '0;
            r_held   <= '0;
            r_behind <= '0;
        end else if (i_accept) begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_bit    <= n_bit;
            r_held   <= n_held;
            r_behind <= n_behind;
        end
    end

    // Shared terms
    assign bits_held = {r_held, {BIT_W{1'b0}}} - BH_W'(r_bit);
    assign amt_x     = MV_W'(i_amount);
    assign bh_x      = MV_W'(bits_held);
    assign limit_x   = MV_W'({r_behind, {BIT_W{1'b0}}}) + MV_W'(r_bit);
    assign room_app  = CNT_W'(BUF_BYTES - 1) - r_held;
    assign nb        = (i_amount > AMT_W'(MAX_READ_BITS)) ? NB_W'(MAX_READ_BITS)
                                                          : i_amount[NB_W-1:0];

    // Decode and next pointers
    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_bit    = r_bit;
        n_held   = r_held;
        n_behind = r_behind;
        moved    = '0;
        do_adv   = 1'b0;
        back_r   = '0;
        back_p7  = '0;
        bytes_b  = '0;
        skip_b   = '0;
        total    = '0;
        bytes_a  = '0;

        o_req            = '0;
        o_req.waddr      = r_wr_idx;
        o_req.wdata      = i_data_byte;
        o_req.raddr      = r_rd_idx;
        o_info           = '0;
        o_info.shift     = r_bit;
        o_info.nvalid    = (r_held > CNT_W'(WORD_BYTES)) ? NV_W'(WORD_BYTES)
                                                         : r_held[NV_W-1:0];

        case (t_mode'(i_mode))
            MODE_APPEND: begin
                if (!r_held[IDX_W]) begin
                    o_req.we = i_accept;
                    n_wr_idx = r_wr_idx + 1'b1;
                    n_held   = r_held + 1'b1;
                    n_behind = (r_behind > room_app) ? room_app : r_behind;
                    moved    = MV_W'(1);
                end
            end
            MODE_READ_BITS: begin
                if (nb != '0) begin
                    o_req.re       = i_accept;
                    o_info.extract = 1'b1;
                    o_info.nbits   = nb;
                    do_adv         = 1'b1;
                    if (MV_W'(nb) > bh_x) begin
                        o_info.short_read = 1'b1;
                        moved             = bh_x;
                    end else begin
                        moved = MV_W'(nb);
                    end
                end
            end
            MODE_SKIP_BITS: begin
                moved  = (amt_x < bh_x) ? amt_x : bh_x;
                do_adv = 1'b1;
            end
            MODE_BACK_BITS: begin
                moved = (amt_x < limit_x) ? amt_x : limit_x;
                if (moved <= MV_W'(r_bit)) begin
                    n_bit = r_bit - moved[BIT_W-1:0];
                end else begin
                    // step back into whole bytes already consumed
                    back_r   = moved - MV_W'(r_bit);
                    back_p7  = (MV_W+1)'(back_r) + (MV_W+1)'(7);
                    bytes_b  = CNT_W'(back_p7 >> BIT_W);
                    n_bit    = BIT_W'(0) - back_r[BIT_W-1:0];
                    n_rd_idx = r_rd_idx - bytes_b[IDX_W-1:0];
                    n_held   = r_held + bytes_b;
                    n_behind = r_behind - bytes_b;
                end
            end
            MODE_SKIP_BYTES: begin
                skip_b   = (amt_x < MV_W'(r_held)) ? CNT_W'(amt_x) : r_held;
                moved    = MV_W'(skip_b);
                n_rd_idx = r_rd_idx + skip_b[IDX_W-1:0];
                n_held   = r_held - skip_b;
                n_behind = r_behind + skip_b;
                n_bit    = '0;
            end
            MODE_READ_BYTE: begin
                if (r_held != '0) begin
                    o_req.re       = i_accept;
                    o_info.extract = 1'b1;
                    o_info.shift   = '0;
                    o_info.nbits   = NB_W'(BYTE_W);
                    n_rd_idx       = r_rd_idx + 1'b1;
                    n_held         = r_held - 1'b1;
                    n_behind       = r_behind + 1'b1;
                    moved          = MV_W'(1);
                end else begin
                    o_info.short_read = 1'b1;
                end
                n_bit = '0;
            end
            default: begin
            end
        endcase

        // Forward move of the read position by a bit count
        if (do_adv) begin
            total    = BH_W'(r_bit) + BH_W'(moved);
            bytes_a  = total[BH_W-1:BIT_W];
            n_rd_idx = r_rd_idx + bytes_a[IDX_W-1:0];
            n_held   = r_held - bytes_a;
            n_behind = r_behind + bytes_a;
            n_bit    = total[BIT_W-1:0];
        end

        o_info.moved   = AMT_W'(moved);
        o_info.avail   = n_held;
        o_info.free    = CNT_W'(BUF_BYTES) - n_held;
        o_info.bit_off = n_bit;
    end

endmodule

[hw/rtl/msbr_store.sv]
module msbr_store
    import msbr_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_win     o_win
);

    // Two banks of words: even words in bank 0, odd words in bank 1
    t_win r_bank0 [BANK_DEPTH];
    t_win r_bank1 [BANK_DEPTH];

    t_win              r_q0, r_q1;
    logic              r_odd_word;
    logic [LANE_W-1:0] r_lane;

    logic [BANK_AW-1:0] row;
    logic               odd_word;
    logic [BANK_AW-1:0] addr0;
    logic [BANK_AW-1:0] waddr_row;
    logic [LANE_W-1:0]  wlane;
    logic               wbank;

    assign row      = i_req.raddr[IDX_W-1:LANE_W+1];
    assign odd_word = i_req.raddr[LANE_W];
    assign addr0    = row + BANK_AW'(odd_word);

    assign waddr_row = i_req.waddr[IDX_W-1:LANE_W+1];
    assign wlane     = i_req.waddr[LANE_W-1:0];
    assign wbank     = i_req.waddr[LANE_W];

    // Byte write into one lane
    always_ff @(posedge i_clk) begin
        if (i_req.we && !wbank) begin
            r_bank0[waddr_row][wlane] <= i_req.wdata;
        end
        if (i_req.we && wbank) begin
            r_bank1[waddr_row][wlane] <= i_req.wdata;
        end
    end

    // Registered read of two consecutive words
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q0       <= r_bank0[addr0];
            r_q1       <= r_bank1[row];
            r_odd_word <= odd_word;
            r_lane     <= i_req.raddr[LANE_W-1:0];
        end
    end

    // Pick four bytes starting at the read lane
    logic [2*WORD_BYTES-1:0][BYTE_W-1:0] seq;
    assign seq = r_odd_word ? {r_q0, r_q1} : {r_q1, r_q0};

    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            o_win[k] = seq[(LANE_W+1)'(r_lane) + (LANE_W+1)'(k)];
        end
    end

endmodule

[hw/rtl/msbr_align.sv]
module msbr_align
    import msbr_pkg::*;
(
    input  t_win             i_win,
    input  t_rd_info         i_info,
    output logic [VAL_W-1:0] o_value
);

    logic [WIN_W-1:0] window;
    logic [WIN_W-1:0] shifted;
    logic [VAL_W-1:0] top;

    // Bytes past the held data read as zero, first byte most significant
    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            window[WIN_W-1-k*BYTE_W -: BYTE_W] =
                (NV_W'(k) < i_info.nvalid) ? i_win[k] : '0;
        end
    end

    assign shifted = window << i_info.shift;
    assign top     = shifted[WIN_W-1 -: VAL_W];
    assign o_value = i_info.extract ? (top >> (NB_W'(VAL_W) - i_info.nbits)) : '0;

endmodule

[hw/rtl/msb_first_bit_reader_buffer_unit.sv]
// Channel | Direction | Handshake        | Payload
// input   | in        | i_valid, o_stall | i_mode, i_data_byte, i_amount
// output  | out       | o_valid, i_stall | o_value, o_moved, o_avail_bytes,
//         |           |                  | o_free_bytes, o_bit_offset, o_short_read
//
// One transaction per cycle while o_stall is low. Pointers update in the accept
// cycle, the byte banks answer the next cycle in the read stage, and the aligned
// value lands in the output register, which drives the result outputs.
// Reset (synchronous, active low) empties the store; no clearing pass.
// A stall on the output backs up through the read stage to o_stall.
module msb_first_bit_reader_buffer_unit
    import msbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [AMT_W-1:0]  i_amount,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_value,
    output logic [AMT_W-1:0]  o_moved,
    output logic [CNT_W-1:0]  o_avail_bytes,
    output logic [CNT_W-1:0]  o_free_bytes,
    output logic [BIT_W-1:0]  o_bit_offset,
    output logic              o_short_read
);

    logic     accept;
    logic     s1_move;
    t_mem_req req;
    t_rd_info info;
    t_win     win;
    logic [VAL_W-1:0] value;

    logic     r_s1_valid, n_s1_valid;
    t_rd_info r_s1_info;
    logic     r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_value;
    t_rd_info r_out_info;

    // Handshake
    assign o_stall    = r_s1_valid && r_out_valid && i_stall;
    assign accept     = i_valid && !o_stall;
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_stall);
    assign n_s1_valid = accept || (r_s1_valid && !s1_move);
    assign n_out_valid = s1_move || (r_out_valid && i_stall);

    msbr_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_amount    (i_amount),
        .o_req       (req),
        .o_info      (info)
    );

    msbr_store u_store (
        .i_clk (i_clk),
        .i_req (req),
        .o_win (win)
    );

    msbr_align u_align (
        .i_win   (win),
        .i_info  (r_s1_info),
        .o_value (value)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Read stage and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
        end
        if (s1_move) begin
            r_value    <= value;
            r_out_info <= r_s1_info;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_value       = r_value;
    assign o_moved       = r_out_info.moved;
    assign o_avail_bytes = r_out_info.avail;
    assign o_free_bytes  = r_out_info.free;
    assign o_bit_offset  = r_out_info.bit_off;
    assign o_short_read  = r_out_info.short_read;

endmodule

[hw/rtl/msbr_chk.sv]
module msbr_chk
    import msbr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [VAL_W-1:0]  o_value,
    input logic [AMT_W-1:0]  o_moved,
    input logic [CNT_W-1:0]  o_avail_bytes,
    input logic [CNT_W-1:0]  o_free_bytes,
    input logic [BIT_W-1:0]  o_bit_offset,
    input logic              o_short_read
);

    // Held plus free always covers the whole store
    a_fill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_avail_bytes + o_free_bytes) == CNT_W'(BUF_BYTES))
        else $error("held and free bytes do not add up to the store size");

    // A short read drains the store to an aligned empty position
    a_short_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_short_read |-> o_avail_bytes == '0 && o_bit_offset == '0)
        else $error("short read left data or a bit offset behind");

    // Nothing held means no partial byte either
    a_empty_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_avail_bytes == '0 |-> o_bit_offset == '0)
        else $error("bit offset set with an empty store");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_moved)
                               && $stable(o_avail_bytes))
        else $error("output transaction changed under stall");

endmodule

bind msb_first_bit_reader_buffer_unit msbr_chk u_msbr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_value       (o_value),
    .o_moved       (o_moved),
    .o_avail_bytes (o_avail_bytes),
    .o_free_bytes  (o_free_bytes),
    .o_bit_offset  (o_bit_offset),
    .o_short_read  (o_short_read)
);

[verif/tb_msb_first_bit_reader_buffer_unit.sv]
module tb_msb_first_bit_reader_buffer_unit;
    import msbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int RAND_ITEMS  = 720;
    localparam int FILL_AT     = 450;   // random items before the drain pause
    localparam int HOLD_AT     = 250;   // transactions sent before the long output hold-off
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_TAIL  = 80;    // last items run with no idling
    localparam int DRAIN_WAIT  = 16;
    localparam longint LIMIT_NS = 8_000_000;

    // Mode codes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
        logic [AMT_W-1:0]  amount;
        logic              drain;   // hold this one back until all results are in
    } t_op;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [AMT_W-1:0] moved;
        logic [CNT_W-1:0] avail;
        logic [CNT_W-1:0] free;
        logic [BIT_W-1:0] bit_off;
        logic             short_read;
    } t_result;

    // DUT signals
    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic [MODE_W-1:0] i_mode      = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic [AMT_W-1:0]  i_amount    = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [VAL_W-1:0]  o_value;
    logic [AMT_W-1:0]  o_moved;
    logic [CNT_W-1:0]  o_avail_bytes;
    logic [CNT_W-1:0]  o_free_bytes;
    logic [BIT_W-1:0]  o_bit_offset;
    logic              o_short_read;

    msb_first_bit_reader_buffer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_data_byte   (i_data_byte),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_moved       (o_moved),
        .o_avail_bytes (o_avail_bytes),
        .o_free_bytes  (o_free_bytes),
        .o_bit_offset  (o_bit_offset),
        .o_short_read  (o_short_read)
    );

    // Pending stimulus and results still owed by the block
    t_op     ops_q[$];
    t_result owed_q[$];

    // Mirror of the byte ring and read position
    logic [BYTE_W-1:0] mirror_bytes [BUF_BYTES];
    int unsigned rd_ptr, wr_ptr, bit_pos, held_bytes, behind_bytes;

    int n_sent, n_checked, n_err;
    int n_refused, n_short, n_trimmed;

    // Clock and reset
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Move the read position forward by n bits (n never exceeds the bits held)
    function automatic void consume_bits(int unsigned n);
        int unsigned total;
        int unsigned nbytes;
        total        = bit_pos + n;
        nbytes       = total >> 3;
        rd_ptr       = (rd_ptr + nbytes) % BUF_BYTES;
        held_bytes   = held_bytes - nbytes;
        behind_bytes = behind_bytes + nbytes;
        bit_pos      = total & 7;
    endfunction

    // Expected result of one transaction; updates the mirror
    function automatic t_result bitstream_predict(logic [MODE_W-1:0] mode,
                                                  logic [BYTE_W-1:0] data,
                                                  logic [AMT_W-1:0]  amount);
        t_result     res;
        int unsigned bits_held;
        int unsigned n;
        int unsigned lim;
        int unsigned r;
        int unsigned nbytes;
        logic [31:0] win;
        res       = '0;
        bits_held = held_bytes * 8 - bit_pos;
        case (mode)
            MODE_APPEND: begin
                if (held_bytes < BUF_BYTES) begin
                    mirror_bytes[wr_ptr] = data;
                    wr_ptr     = (wr_ptr + 1) % BUF_BYTES;
                    held_bytes = held_bytes + 1;
                    // oldest consumed byte just got overwritten
                    if (behind_bytes > BUF_BYTES - held_bytes) begin
                        behind_bytes = BUF_BYTES - held_bytes;
                        n_trimmed++;
                    end
                    res.moved = 1;
                end else begin
                    n_refused++;
                end
            end
            MODE_READ_BITS: begin
                n = (amount > MAX_READ_BITS) ? MAX_READ_BITS : amount;
                if (n > 0) begin
                    win = '0;
                    for (int k = 0; k < WORD_BYTES; k++) begin
                        win = {win[23:0],
                               (k < held_bytes) ? mirror_bytes[(rd_ptr + k) % BUF_BYTES]
                                                : 8'h00};
                    end
                    win       = win << bit_pos;
                    res.value = VAL_W'(win >> (32 - n));
                    if (n > bits_held) begin
                        res.short_read = 1'b1;
                        n_short++;
                        n = bits_held;
                    end
                    res.moved = AMT_W'(n);
                    consume_bits(n);
                end
            end
            MODE_SKIP_BITS: begin
                n = (amount < bits_held) ? amount : bits_held;
                res.moved = AMT_W'(n);
                consume_bits(n);
            end
            MODE_BACK_BITS: begin
                lim = behind_bytes * 8 + bit_pos;
                n   = (amount < lim) ? amount : lim;
                res.moved = AMT_W'(n);
                if (n <= bit_pos) begin
                    bit_pos = bit_pos - n;
                end else begin
                    r            = n - bit_pos;
                    nbytes       = (r + 7) >> 3;
                    bit_pos      = (nbytes * 8 - r) & 7;
                    rd_ptr       = (rd_ptr + BUF_BYTES - (nbytes % BUF_BYTES)) % BUF_BYTES;
                    held_bytes   = held_bytes + nbytes;
                    behind_bytes = behind_bytes - nbytes;
                end
            end
            MODE_SKIP_BYTES: begin
                n = (amount < held_bytes) ? amount : held_bytes;
                res.moved    = AMT_W'(n);
                rd_ptr       = (rd_ptr + n) % BUF_BYTES;
                held_bytes   = held_bytes - n;
                behind_bytes = behind_bytes + n;
                bit_pos      = 0;
            end
            MODE_READ_BYTE: begin
                if (held_bytes > 0) begin
                    res.value    = VAL_W'(mirror_bytes[rd_ptr]);
                    rd_ptr       = (rd_ptr + 1) % BUF_BYTES;
                    held_bytes   = held_bytes - 1;
                    behind_bytes = behind_bytes + 1;
                    res.moved    = 1;
                end else begin
                    res.short_read = 1'b1;
                    n_short++;
                end
                bit_pos = 0;
            end
            default: ;  // spare modes leave everything alone
        endcase
        res.avail   = CNT_W'(held_bytes);
        res.free    = CNT_W'(BUF_BYTES - held_bytes);
        res.bit_off = BIT_W'(bit_pos);
        return res;
    endfunction

    function automatic void add_op(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                                   logic [AMT_W-1:0] amount, logic drain = 1'b0);
        t_op op;
        op.mode   = mode;
        op.data   = data;
        op.amount = amount;
        op.drain  = drain;
        ops_q.push_back(op);
    endfunction

    // Mostly small counts, now and then anything the field allows
    function automatic logic [AMT_W-1:0] pick_amount(int unsigned small_max);
        if ($urandom_range(0, 5) == 0)
            return AMT_W'($urandom);
        return AMT_W'($urandom_range(0, small_max));
    endfunction

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    int send_gap = 0;

    // Input driver: a new transaction once the previous one is taken, bar random gaps and drain pauses
    always @(posedge i_clk) begin
        t_op  op;
        logic fire;
        logic nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire      = i_valid && !o_stall;
            nxt_valid = i_valid;
            if (fire) begin
                owed_q.push_back(bitstream_predict(i_mode, i_data_byte, i_amount));
                n_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (ops_q.size() == 0) begin
                    // nothing left to send
                end else if (ops_q[0].drain && owed_q.size() != 0) begin
                    // paused until the block has returned everything
                end else if (ops_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 5);
                end else begin
                    op = ops_q.pop_front();
                    i_mode      <= op.mode;
                    i_data_byte <= op.data;
                    i_amount    <= op.amount;
                    nxt_valid   = 1'b1;
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // Output stall: random bursts plus one long hold-off
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    always @(posedge i_clk) begin
        logic nxt_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            nxt_stall = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                nxt_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else if (ops_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                nxt_stall  = 1'b1;
            end
            i_stall <= nxt_stall;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.value      = o_value;
            got.moved      = o_moved;
            got.avail      = o_avail_bytes;
            got.free       = o_free_bytes;
            got.bit_off    = o_bit_offset;
            got.short_read = o_short_read;
            if (owed_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: result with none expected: value %h moved %0d", o_value,
                             o_moved);
            end else begin
                want = owed_q.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display({"ERROR: transaction %0d exp/got value %h/%h moved %0d/%0d",
                                  " avail %0d/%0d free %0d/%0d bit %0d/%0d short %0b/%0b"},
                                 n_checked, want.value, got.value, want.moved, got.moved,
                                 want.avail, got.avail, want.free, got.free,
                                 want.bit_off, got.bit_off, want.short_read, got.short_read);
                end
            end
        end
    end

    // Stimulus, end of run and report
    initial begin
        int n_rand;
        int sel;
        bit filled;
        for (int i = 0; i < BUF_BYTES; i++)
            mirror_bytes[i] = '0;
        rd_ptr = 0; wr_ptr = 0; bit_pos = 0; held_bytes = 0; behind_bytes = 0;
        n_sent = 0; n_checked = 0; n_err = 0;
        n_refused = 0; n_short = 0; n_trimmed = 0;
        n_rand = 0;
        filled = 1'b0;

        // Directed: empty store, spare modes, extremes of every operation
        add_op(MODE_READ_BYTE,  8'h00, 16'h0000);
        add_op(MODE_READ_BITS,  8'hff, 16'd8);
        add_op(MODE_SKIP_BITS,  8'h00, 16'hffff);
        add_op(MODE_BACK_BITS,  8'hff, 16'hffff);
        add_op(MODE_SKIP_BYTES, 8'h00, 16'hffff);
        add_op(MODE_SPARE_LO,   8'hff, 16'hffff);
        add_op(MODE_SPARE_HI,   8'h5a, 16'h1234);
        add_op(MODE_APPEND,     8'hff, 16'hffff);
        add_op(MODE_APPEND,     8'h00, 16'h0000);
        add_op(MODE_APPEND,     8'ha5, 16'h0000);
        add_op(MODE_APPEND,     8'h5a, 16'h0000);
        add_op(MODE_APPEND,     8'hc3, 16'h0000);
        add_op(MODE_READ_BITS,  8'h00, 16'd0);      // zero-width read
        add_op(MODE_READ_BITS,  8'h00, 16'd3);
        add_op(MODE_READ_BITS,  8'h00, 16'hffff);   // width saturates
        add_op(MODE_BACK_BITS,  8'h00, 16'd5);      // back across a byte edge
        add_op(MODE_BACK_BITS,  8'h00, 16'hffff);   // back to the oldest stored byte
        add_op(MODE_SKIP_BITS,  8'h00, 16'd13);
        add_op(MODE_READ_BYTE,  8'h00, 16'h0000);
        add_op(MODE_SKIP_BYTES, 8'h00, 16'd1);
        add_op(MODE_READ_BITS,  8'h00, 16'd24);     // runs past the held data
        add_op(MODE_SKIP_BYTES, 8'h00, 16'hffff);
        add_op(MODE_READ_BITS,  8'h00, 16'd1);

        // Random: mostly append-then-consume sequences, some noise
        while (n_rand < RAND_ITEMS) begin
            if (!filled && n_rand >= FILL_AT) begin
                // sender waits for every result, then the extremes once more
                filled = 1'b1;
                add_op(MODE_APPEND,     any_byte(), AMT_W'($urandom), 1'b1);
                add_op(MODE_READ_BITS,  any_byte(), 16'd24);
                add_op(MODE_SKIP_BITS,  any_byte(), 16'hffff);
                add_op(MODE_BACK_BITS,  any_byte(), 16'hffff);
                add_op(MODE_SKIP_BYTES, any_byte(), 16'd100);
                add_op(MODE_BACK_BITS,  any_byte(), 16'hffff);
                add_op(MODE_SKIP_BYTES, any_byte(), 16'hffff);
            end
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 12)) begin
                    add_op(MODE_APPEND, any_byte(), AMT_W'($urandom));
                    n_rand++;
                end
                repeat ($urandom_range(1, 10)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 5)
                        add_op(MODE_READ_BITS, any_byte(),
                               ($urandom_range(0, 7) == 0) ? AMT_W'($urandom)
                                                           : AMT_W'($urandom_range(1, 24)));
                    else if (sel == 5)
                        add_op(MODE_SKIP_BITS, any_byte(), pick_amount(40));
                    else if (sel == 6)
                        add_op(MODE_BACK_BITS, any_byte(), pick_amount(40));
                    else if (sel == 7)
                        add_op(MODE_SKIP_BYTES, any_byte(), pick_amount(4));
                    else
                        add_op(MODE_READ_BYTE, any_byte(), AMT_W'($urandom));
                    n_rand++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    add_op(MODE_W'($urandom_range(0, 7)), any_byte(), pick_amount(64));
                    n_rand++;
                end
            end
        end

        // Wait for the last transaction to go in and its result to come out
        while (!(i_rst_n && ops_q.size() == 0 && !i_valid && owed_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (owed_q.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", owed_q.size());
            n_err += owed_q.size();
        end
        $display("Run: %0d transactions sent, %0d results checked, %0d mismatches.",
                 n_sent, n_checked, n_err);
        $display("Seen: %0d appends refused on a full store, %0d short reads, %0d overwrites.",
                 n_refused, n_short, n_trimmed);
        if (n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("ERROR: timeout, %0d results still owed", owed_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
